// ===== design/i2c_eeprom_access_master_unit_assert.svh =====
// Assertion macros used by the bus sequencer RTL of the EEPROM access master.
`ifndef I2C_EEPROM_ACCESS_MASTER_UNIT_ASSERT_SVH
`define I2C_EEPROM_ACCESS_MASTER_UNIT_ASSERT_SVH

// Condition a must bring condition b in the same cycle.
`define IEAM_ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) ((a) |-> (b))) \
    else $error("implication check failed");

// Condition a must never hold.
`define IEAM_ASSERT_NEVER(label, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("forbidden condition seen");

`endif

// ===== design/ieam_pkg.sv =====
// Shared types and constants of the EEPROM access master.
`timescale 1ns / 1ps
package ieam_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BUSY   = 2'd1;
  localparam logic [1:0] STAT_BUSERR = 2'd2;
  localparam logic [1:0] STAT_NOACK  = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        is_req;
    logic        is_read;
    logic [10:0] mem_address;
    logic [7:0]  write_data;
    logic [7:0]  read_length;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ===== design/ieam_front.sv =====
// Input side: takes words, classifies the request and queues them.
`timescale 1ns / 1ps
module ieam_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [10:0]          mem_address,
  input  logic [7:0]           write_data,
  input  logic [7:0]           read_length,
  input  logic                 sda_in,
  output ieam_pkg::queue_head_t head,
  input  logic                 pop
);

  ieam_pkg::item_t slots [ieam_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;
  ieam_pkg::item_t cls;

  always_comb begin
    cls.is_req      = (req_type == ieam_pkg::REQ_WRITE) || (req_type == ieam_pkg::REQ_READ);
    cls.is_read     = (req_type == ieam_pkg::REQ_READ);
    cls.mem_address = mem_address;
    cls.write_data  = write_data;
    cls.read_length = read_length;
    cls.sda_in      = sda_in;
  end

  assign in_stall   = (count == 2'(ieam_pkg::QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign take       = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(take);
    end
  end

endmodule

// ===== design/ieam_back.sv =====
// Bus sequencer: runs one tick per queued word and registers the result.
`timescale 1ns / 1ps
module ieam_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ieam_pkg::queue_head_t head,
  output logic                  pop,
  input  logic [7:0]            device_address,
  input  logic [7:0]            phase_ticks,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  scl_out,
  output logic                  sda_out,
  output logic                  byte_valid,
  output logic [7:0]            read_data,
  output logic                  byte_last,
  output logic                  done_res,
  output logic [1:0]            status,
  output logic                  busy_res
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_CTRL, ST_ACK1, ST_LO, ST_ACK2, ST_DATA, ST_ACK3,
    ST_RSTART, ST_RCTRL, ST_ACK4, ST_RECV, ST_MACK, ST_STOP, ST_STOPNA
  } stage_t;

  typedef struct packed {
    stage_t      stage;
    logic [1:0]  sub;
    logic [7:0]  tick;
    logic [3:0]  bitc;
    logic [7:0]  shift;
    logic [7:0]  left;
    logic [10:0] addr;
    logic [7:0]  data;
    logic        rmode;
    logic        scl;
    logic        sda;
  } seq_t;

  function automatic seq_t enter(seq_t s, stage_t stg, logic [1:0] sb);
    seq_t r;
    r       = s;
    r.stage = stg;
    r.sub   = sb;
    r.tick  = 8'd0;
    unique case (stg)
      ST_START, ST_RSTART: begin
        if (sb == 2'd0) begin
          r.sda = 1'b1;
          r.scl = 1'b1;
        end else r.sda = 1'b0;
      end
      ST_CTRL, ST_LO, ST_DATA, ST_RCTRL: begin
        if (sb == 2'd0) r.scl = 1'b0;
        else if (sb == 2'd1) r.sda = s.shift[3'd7 - s.bitc[2:0]];
        else r.scl = 1'b1;
      end
      ST_ACK1, ST_ACK2, ST_ACK3, ST_ACK4: begin
        if (sb == 2'd0) r.scl = 1'b0;
        else if (sb == 2'd1) r.sda = 1'b1;
        else r.scl = 1'b1;
      end
      ST_RECV: begin
        if (sb == 2'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b1;
        end else r.scl = 1'b1;
      end
      ST_MACK: begin
        if (sb == 2'd1) r.sda = (s.left == 8'd0);
        else r.scl = (sb == 2'd2);
      end
      ST_STOP, ST_STOPNA: begin
        if (sb == 2'd0) r.scl = 1'b0;
        else if (sb == 2'd1) r.sda = 1'b0;
        else if (sb == 2'd2) r.scl = 1'b1;
        else r.sda = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic seq_t go_send(seq_t s, stage_t stg, logic [7:0] v);
    seq_t r;
    r       = s;
    r.shift = v;
    r.bitc  = 4'd0;
    return enter(r, stg, 2'd0);
  endfunction

  seq_t       cur;
  seq_t       n;
  logic       take;
  logic       s_in;
  logic [7:0] limit;
  logic [7:0] ctrl_wr;
  logic [7:0] ctrl_rd;
  logic       o_scl, o_sda, o_v, o_last, o_done, o_busy;
  logic [7:0] o_rd;
  logic [1:0] o_stat;

  assign take = !out_valid || !out_stall;
  assign pop  = take && head.valid;
  assign s_in = head.item.sda_in;

  always_comb begin
    n      = cur;
    o_v    = 1'b0;
    o_rd   = 8'd0;
    o_last = 1'b0;
    o_done = 1'b0;
    o_stat = ieam_pkg::STAT_OK;
    o_busy = 1'b0;
    limit  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    if (cur.stage == ST_IDLE && head.item.is_req) begin
      n.addr  = head.item.mem_address;
      n.data  = head.item.write_data;
      n.left  = head.item.read_length;
      n.rmode = head.item.is_read;
      n       = enter(n, ST_START, 2'd0);
    end
    ctrl_wr = {4'd0, n.addr[10:8], 1'b0} | (device_address & 8'hFE);
    ctrl_rd = {4'd0, n.addr[10:8], 1'b0} | device_address | 8'h01;
    o_scl   = n.scl;
    o_sda   = n.sda;
    if (n.stage != ST_IDLE) begin
      o_busy = 1'b1;
      n.tick = n.tick + 8'd1;
      if (n.tick >= limit) begin
        unique case (n.stage)
          ST_START, ST_RSTART: begin
            if ((n.sub == 2'd0 && !s_in) || (n.sub == 2'd1 && s_in) || n.sub[1]) begin
              if (!n.sub[1] && n.stage == ST_START) begin
                o_done  = 1'b1;
                o_stat  = (n.sub == 2'd0) ? ieam_pkg::STAT_BUSY : ieam_pkg::STAT_BUSERR;
                n.stage = ST_IDLE;
                n.sub   = 2'd0;
                n.tick  = 8'd0;
              end else if (n.stage == ST_START) n = go_send(n, ST_CTRL, ctrl_wr);
              else n = go_send(n, ST_RCTRL, ctrl_rd);
            end else n = enter(n, n.stage, n.sub + 2'd1);
          end
          ST_CTRL, ST_LO, ST_DATA, ST_RCTRL: begin
            if (n.sub < 2'd2) n = enter(n, n.stage, n.sub + 2'd1);
            else begin
              n.bitc = n.bitc + 4'd1;
              if (n.bitc >= 4'd8) begin
                n.bitc = 4'd0;
                unique case (n.stage)
                  ST_CTRL: n = enter(n, ST_ACK1, 2'd0);
                  ST_LO:   n = enter(n, ST_ACK2, 2'd0);
                  ST_DATA: n = enter(n, ST_ACK3, 2'd0);
                  default: n = enter(n, ST_ACK4, 2'd0);
                endcase
              end else n = enter(n, n.stage, 2'd0);
            end
          end
          ST_ACK1, ST_ACK2, ST_ACK3, ST_ACK4: begin
            if (n.sub < 2'd2) n = enter(n, n.stage, n.sub + 2'd1);
            else begin
              unique case (n.stage)
                ST_ACK1: n = s_in ? enter(n, ST_STOPNA, 2'd0)
                                  : go_send(n, ST_LO, n.addr[7:0]);
                ST_ACK2: n = n.rmode ? enter(n, ST_RSTART, 2'd0)
                                     : go_send(n, ST_DATA, n.data);
                ST_ACK3: n = enter(n, ST_STOP, 2'd0);
                default: n = (n.left == 8'd0) ? enter(n, ST_STOP, 2'd0)
                                              : go_send(n, ST_RECV, 8'd0);
              endcase
            end
          end
          ST_RECV: begin
            if (n.sub == 2'd0) n = enter(n, ST_RECV, 2'd1);
            else begin
              n.shift = {n.shift[6:0], s_in};
              n.bitc  = n.bitc + 4'd1;
              if (n.bitc >= 4'd8) begin
                o_v    = 1'b1;
                o_rd   = n.shift;
                o_last = (n.left <= 8'd1);
                if (n.left != 8'd0) n.left = n.left - 8'd1;
                n.bitc = 4'd0;
                n      = enter(n, ST_MACK, 2'd0);
              end else n = enter(n, ST_RECV, 2'd0);
            end
          end
          ST_MACK: begin
            if (n.sub < 2'd3) n = enter(n, ST_MACK, n.sub + 2'd1);
            else if (n.left == 8'd0) n = enter(n, ST_STOP, 2'd0);
            else n = go_send(n, ST_RECV, 8'd0);
          end
          ST_STOP, ST_STOPNA: begin
            if (n.sub < 2'd3) n = enter(n, n.stage, n.sub + 2'd1);
            else begin
              o_done  = 1'b1;
              o_stat  = (n.stage == ST_STOPNA) ? ieam_pkg::STAT_NOACK : ieam_pkg::STAT_OK;
              n.stage = ST_IDLE;
              n.sub   = 2'd0;
              n.tick  = 8'd0;
            end
          end
          default: begin
            n.stage = ST_IDLE;
            n.sub   = 2'd0;
            n.tick  = 8'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scl_out    <= o_scl;
      sda_out    <= o_sda;
      byte_valid <= o_v;
      read_data  <= o_rd;
      byte_last  <= o_last;
      done_res   <= o_done;
      status     <= o_stat;
      busy_res   <= o_busy;
    end
    if (rst) begin
      cur       <= '{stage: ST_IDLE, sub: 2'd0, tick: 8'd0, bitc: 4'd0, shift: 8'd0,
                     left: 8'd0, addr: 11'd0, data: 8'd0, rmode: 1'b0, scl: 1'b1,
                     sda: 1'b1};
      out_valid <= 1'b0;
    end else begin
      if (pop) cur <= n;
      if (take) out_valid <= head.valid;
    end
  end

`include "i2c_eeprom_access_master_unit_assert.svh"

  `IEAM_ASSERT_IMPL(a_status_needs_done, out_valid && status != ieam_pkg::STAT_OK, done_res)
  `IEAM_ASSERT_IMPL(a_last_needs_byte, out_valid && byte_last, byte_valid)
  `IEAM_ASSERT_IMPL(a_done_while_busy, out_valid && done_res, busy_res)
  `IEAM_ASSERT_NEVER(a_idle_holds_tick, cur.stage == ST_IDLE && cur.tick != 8'd0)

endmodule

// ===== design/i2c_eeprom_access_master_unit.sv =====
// Top level of the I2C master for 24Cxx-style EEPROM random write and read.
// Each input word is one bus tick and yields one output word; one word is
// taken per clock unless out_stall holds the output; the sequencer step sits
// behind a two-word queue, and the queue and the result are both registered.
// Each bus phase lasts phase_ticks words, or one word when phase_ticks is zero.
`timescale 1ns / 1ps
module i2c_eeprom_access_master_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [10:0] mem_address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  read_length,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_out,
  output logic        sda_out,
  output logic        byte_valid,
  output logic [7:0]  read_data,
  output logic        byte_last,
  output logic        done_res,
  output logic [1:0]  status,
  output logic        busy_res
);

  logic [7:0] device_address;
  logic [7:0] phase_ticks;
  ieam_pkg::queue_head_t head;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'hA0;
      phase_ticks    <= 8'd10;
    end else if (cfg_write) begin
      if (cfg_index) phase_ticks <= cfg_data;
      else device_address <= cfg_data;
    end
  end

  ieam_front u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .mem_address, .write_data,
    .read_length, .sda_in, .head, .pop
  );

  ieam_back u_back (
    .clk, .rst, .head, .pop, .device_address, .phase_ticks, .out_valid,
    .out_stall, .scl_out, .sda_out, .byte_valid, .read_data, .byte_last,
    .done_res, .status, .busy_res
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the I2C EEPROM access master: tick words in, bus words out.
`timescale 1ns / 1ps
module tb;

  localparam logic [3:0] SEQ_IDLE   = 4'd0;
  localparam logic [3:0] SEQ_START  = 4'd1;
  localparam logic [3:0] SEQ_CTRL   = 4'd2;
  localparam logic [3:0] SEQ_ACK1   = 4'd3;
  localparam logic [3:0] SEQ_LO     = 4'd4;
  localparam logic [3:0] SEQ_ACK2   = 4'd5;
  localparam logic [3:0] SEQ_DATA   = 4'd6;
  localparam logic [3:0] SEQ_ACK3   = 4'd7;
  localparam logic [3:0] SEQ_RSTART = 4'd8;
  localparam logic [3:0] SEQ_RCTRL  = 4'd9;
  localparam logic [3:0] SEQ_ACK4   = 4'd10;
  localparam logic [3:0] SEQ_RECV   = 4'd11;
  localparam logic [3:0] SEQ_MACK   = 4'd12;
  localparam logic [3:0] SEQ_STOP   = 4'd13;
  localparam logic [3:0] SEQ_STOPNA = 4'd14;

  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_PHASE_TICKS    = 1'b1;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [10:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  rlen;
    logic        sda;
  } tick_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       bvalid;
    logic [7:0] rdata;
    logic       blast;
    logic       done;
    logic [1:0] stat;
    logic       busy;
  } bus_word_t;

  typedef struct {
    tick_word_t w;
    bit         chk;
    bus_word_t  r;
  } script_row_t;

  logic        clk, rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  req_type;
  logic [10:0] mem_address;
  logic [7:0]  write_data, read_length;
  logic        sda_in;
  logic        out_valid, out_stall;
  logic        scl_out, sda_out, byte_valid, byte_last, done_res, busy_res;
  logic [7:0]  read_data;
  logic [1:0]  status;

  i2c_eeprom_access_master_unit dut (.*);

  // sequencer model state
  logic [7:0]  dev_addr, phase_len;
  logic [3:0]  m_stage;
  logic [1:0]  m_sub;
  logic [7:0]  m_ticks, m_bits, m_shift, m_left, m_data;
  logic [10:0] m_addr;
  logic        m_rmode, m_scl, m_sda;

  bus_word_t bus_expect_q[$];
  int        fail_count = 0;
  bit        idling_on = 1;
  int        stall_left = 0;
  int        max_len = 4;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void enter(logic [3:0] st, logic [1:0] sb);
    m_stage = st;
    m_sub = sb;
    m_ticks = 0;
    case (st)
      SEQ_START, SEQ_RSTART: begin
        if (sb == 0) begin
          m_sda = 1;
          m_scl = 1;
        end else m_sda = 0;
      end
      SEQ_CTRL, SEQ_LO, SEQ_DATA, SEQ_RCTRL: begin
        if (sb == 0) m_scl = 0;
        else if (sb == 1) m_sda = m_shift[3'd7 - m_bits[2:0]];
        else m_scl = 1;
      end
      SEQ_ACK1, SEQ_ACK2, SEQ_ACK3, SEQ_ACK4: begin
        if (sb == 0) m_scl = 0;
        else if (sb == 1) m_sda = 1;
        else m_scl = 1;
      end
      SEQ_RECV: begin
        if (sb == 0) begin
          m_scl = 0;
          m_sda = 1;
        end else m_scl = 1;
      end
      SEQ_MACK: begin
        if (sb == 1) m_sda = (m_left == 0);
        else m_scl = (sb == 2);
      end
      SEQ_STOP, SEQ_STOPNA: begin
        if (sb == 0) m_scl = 0;
        else if (sb == 1) m_sda = 0;
        else if (sb == 2) m_scl = 1;
        else m_sda = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic void send_byte(logic [3:0] st, logic [7:0] v);
    m_shift = v;
    m_bits = 0;
    enter(st, 0);
  endfunction

  function automatic void recv_byte();
    m_shift = 0;
    m_bits = 0;
    enter(SEQ_RECV, 0);
  endfunction

  function automatic void finish_txn(ref bus_word_t r, input logic [1:0] st);
    r.done = 1;
    r.stat = st;
    m_stage = SEQ_IDLE;
    m_sub = 0;
    m_ticks = 0;
  endfunction

  // Advance the sequencer model by one tick and return the bus word it drives.
  function automatic bus_word_t sequencer_tick(tick_word_t w);
    bus_word_t r;
    logic [7:0] lim;
    r = '0;
    if (m_stage == SEQ_IDLE &&
        (w.req == ieam_pkg::REQ_WRITE || w.req == ieam_pkg::REQ_READ)) begin
      m_addr = w.addr;
      m_data = w.wdata;
      m_left = w.rlen;
      m_rmode = (w.req == ieam_pkg::REQ_READ);
      enter(SEQ_START, 0);
    end
    r.scl = m_scl;
    r.sda = m_sda;
    if (m_stage != SEQ_IDLE) begin
      r.busy = 1;
      lim = (phase_len == 0) ? 8'd1 : phase_len;
      m_ticks = m_ticks + 8'd1;
      if (m_ticks >= lim) begin
        case (m_stage)
          SEQ_START, SEQ_RSTART: begin
            if ((m_sub == 0 && !w.sda) || (m_sub == 1 && w.sda) || m_sub >= 2) begin
              if (m_sub < 2 && m_stage == SEQ_START)
                finish_txn(r, (m_sub == 0) ? ieam_pkg::STAT_BUSY : ieam_pkg::STAT_BUSERR);
              else if (m_stage == SEQ_START)
                send_byte(SEQ_CTRL, {4'b0, m_addr[10:8], 1'b0} | (dev_addr & 8'hFE));
              else
                send_byte(SEQ_RCTRL, {4'b0, m_addr[10:8], 1'b0} | dev_addr | 8'h01);
            end else enter(m_stage, m_sub + 2'd1);
          end
          SEQ_CTRL, SEQ_LO, SEQ_DATA, SEQ_RCTRL: begin
            if (m_sub < 2) enter(m_stage, m_sub + 2'd1);
            else begin
              m_bits = m_bits + 8'd1;
              if (m_bits >= 8) begin
                m_bits = 0;
                enter(m_stage + 4'd1, 0);
              end else enter(m_stage, 0);
            end
          end
          SEQ_ACK1, SEQ_ACK2, SEQ_ACK3, SEQ_ACK4: begin
            if (m_sub < 2) enter(m_stage, m_sub + 2'd1);
            else if (m_stage == SEQ_ACK1) begin
              if (w.sda) enter(SEQ_STOPNA, 0);
              else send_byte(SEQ_LO, m_addr[7:0]);
            end else if (m_stage == SEQ_ACK2) begin
              if (m_rmode) enter(SEQ_RSTART, 0);
              else send_byte(SEQ_DATA, m_data);
            end else if (m_stage == SEQ_ACK3) enter(SEQ_STOP, 0);
            else if (m_left == 0) enter(SEQ_STOP, 0);
            else recv_byte();
          end
          SEQ_RECV: begin
            if (m_sub == 0) enter(SEQ_RECV, 1);
            else begin
              m_shift = {m_shift[6:0], w.sda};
              m_bits = m_bits + 8'd1;
              if (m_bits >= 8) begin
                r.bvalid = 1;
                r.rdata = m_shift;
                r.blast = (m_left <= 1);
                if (m_left != 0) m_left = m_left - 8'd1;
                m_bits = 0;
                enter(SEQ_MACK, 0);
              end else enter(SEQ_RECV, 0);
            end
          end
          SEQ_MACK: begin
            if (m_sub < 3) enter(SEQ_MACK, m_sub + 2'd1);
            else if (m_left == 0) enter(SEQ_STOP, 0);
            else recv_byte();
          end
          SEQ_STOP, SEQ_STOPNA: begin
            if (m_sub < 3) enter(m_stage, m_sub + 2'd1);
            else finish_txn(r, (m_stage == SEQ_STOPNA) ? ieam_pkg::STAT_NOACK
                                                       : ieam_pkg::STAT_OK);
          end
          default: begin
            m_stage = SEQ_IDLE;
            m_sub = 0;
            m_ticks = 0;
          end
        endcase
      end
    end
    return r;
  endfunction

  // SDA as a mostly well-behaved EEPROM would show it, with some noise.
  function automatic logic slave_sda();
    int p;
    p = $urandom_range(0, 99);
    case (m_stage)
      SEQ_START: return (m_sub == 0) ? (p >= 4) : (p < 4);
      SEQ_ACK1:  return p < 8;
      SEQ_ACK2, SEQ_ACK3, SEQ_ACK4: return p < 15;
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic tick_word_t random_word();
    tick_word_t w;
    int p;
    w.addr = 11'($urandom_range(0, 2047));
    w.wdata = 8'($urandom_range(0, 255));
    w.rlen = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, max_len))
                                          : 8'($urandom_range(0, (max_len < 4) ? max_len : 4));
    w.sda = slave_sda();
    p = $urandom_range(0, 99);
    if (m_stage == SEQ_IDLE)
      w.req = (p < 40) ? ieam_pkg::REQ_WRITE : (p < 80) ? ieam_pkg::REQ_READ :
              (p < 90) ? REQ_UNUSED : ieam_pkg::REQ_TICK;
    else
      w.req = (p < 90) ? ieam_pkg::REQ_TICK : 2'($urandom_range(0, 3));
    return w;
  endfunction

  // Drive one word, hold it until taken, then predict its bus word.
  task automatic send_word(tick_word_t w, bit chk, bus_word_t want);
    bus_word_t got;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1;
    req_type <= w.req;
    mem_address <= w.addr;
    write_data <= w.wdata;
    read_length <= w.rlen;
    sda_in <= w.sda;
    do @(posedge clk); while (in_stall);
    got = sequencer_tick(w);
    if (chk && got !== want)
      $error("directed row disagrees with sequencer model: %h vs %h", want, got);
    bus_expect_q.push_back(chk ? want : got);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (bus_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic finish_and_drain();
    while (m_stage != SEQ_IDLE) send_word(random_tick(), 0, '0);
    drain();
  endtask

  function automatic tick_word_t random_tick();
    tick_word_t w;
    w = random_word();
    w.req = ieam_pkg::REQ_TICK;
    return w;
  endfunction

  task automatic write_reg(logic idx, logic [7:0] v);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 0;
    if (idx == CFG_DEVICE_ADDRESS) dev_addr = v;
    else phase_len = v;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1;
    end else out_stall <= 0;
  end

  always @(posedge clk) begin
    bus_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (bus_expect_q.size() == 0) begin
        $error("bus word with nothing expected");
        fail_count++;
      end else begin
        e = bus_expect_q.pop_front();
        if (scl_out !== e.scl) begin
          $error("scl_out: expected %0d got %0d", e.scl, scl_out); fail_count++;
        end
        if (sda_out !== e.sda) begin
          $error("sda_out: expected %0d got %0d", e.sda, sda_out); fail_count++;
        end
        if (byte_valid !== e.bvalid) begin
          $error("byte_valid: expected %0d got %0d", e.bvalid, byte_valid); fail_count++;
        end
        if (read_data !== e.rdata) begin
          $error("read_data: expected %0h got %0h", e.rdata, read_data); fail_count++;
        end
        if (byte_last !== e.blast) begin
          $error("byte_last: expected %0d got %0d", e.blast, byte_last); fail_count++;
        end
        if (done_res !== e.done) begin
          $error("done_res: expected %0d got %0d", e.done, done_res); fail_count++;
        end
        if (status !== e.stat) begin
          $error("status: expected %0d got %0d", e.stat, status); fail_count++;
        end
        if (busy_res !== e.busy) begin
          $error("busy_res: expected %0d got %0d", e.busy, busy_res); fail_count++;
        end
      end
    end
  end

  initial begin
    script_row_t script[$];
    logic [7:0] dev_set[6] = '{8'hA0, 8'h00, 8'hFF, 8'h5B, 8'h00, 8'h3C};
    logic [7:0] len_set[6] = '{8'd3, 8'd1, 8'd2, 8'd0, 8'd1, 8'd2};
    int max_set[6] = '{4, 6, 4, 6, 2, 4};
    int cnt_set[6] = '{30, 40, 30, 30, 20, 30};
    int n;
    rst = 1;
    cfg_write = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; req_type = ieam_pkg::REQ_TICK; mem_address = 0;
    write_data = 0; read_length = 0; sda_in = 1; out_stall = 0;
    dev_addr = 8'hA0; phase_len = 8'd10;
    m_stage = SEQ_IDLE; m_sub = 0; m_ticks = 0; m_bits = 0; m_shift = 0;
    m_left = 0; m_addr = 0; m_data = 0; m_rmode = 0; m_scl = 1; m_sda = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // quick bus-condition checks at one tick per phase
    write_reg(CFG_PHASE_TICKS, 8'd1);
    script.push_back('{'{ieam_pkg::REQ_TICK, 11'd0, 8'd0, 8'd0, 1'b1}, 1,
                       '{1, 1, 0, 8'd0, 0, 0, ieam_pkg::STAT_OK, 0}});
    script.push_back('{'{ieam_pkg::REQ_WRITE, 11'd0, 8'd0, 8'd0, 1'b0}, 1,
                       '{1, 1, 0, 8'd0, 0, 1, ieam_pkg::STAT_BUSY, 1}});
    script.push_back('{'{ieam_pkg::REQ_READ, 11'd2047, 8'd255, 8'd255, 1'b1}, 1,
                       '{1, 1, 0, 8'd0, 0, 0, ieam_pkg::STAT_OK, 1}});
    script.push_back('{'{ieam_pkg::REQ_TICK, 11'd0, 8'd0, 8'd0, 1'b1}, 1,
                       '{1, 0, 0, 8'd0, 0, 1, ieam_pkg::STAT_BUSERR, 1}});
    script.push_back('{'{REQ_UNUSED, 11'd2047, 8'd255, 8'd255, 1'b0}, 0, '0});
    script.push_back('{'{ieam_pkg::REQ_WRITE, 11'd2047, 8'd255, 8'd255, 1'b1}, 0, '0});
    script.push_back('{'{ieam_pkg::REQ_READ, 11'd0, 8'd0, 8'd0, 1'b0}, 0, '0});
    for (int i = 0; i < 14; i++)
      script.push_back('{'{ieam_pkg::REQ_TICK, 11'd1365, 8'hAA, 8'd0, i[0]}, 0, '0});
    script.push_back('{'{ieam_pkg::REQ_READ, 11'd0, 8'd0, 8'd0, 1'b0}, 0, '0});
    foreach (script[i]) send_word(script[i].w, script[i].chk, script[i].r);
    finish_and_drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_DEVICE_ADDRESS, dev_set[ph]);
      write_reg(CFG_PHASE_TICKS, len_set[ph]);
      max_len = max_set[ph];
      idling_on = (ph != 5);
      n = cnt_set[ph];
      for (int i = 0; i < n; i++) begin
        if (ph == 1 && i == 20) drain();
        send_word(random_word(), 0, '0);
      end
      finish_and_drain();
    end

    in_valid <= 0;
    repeat (10) @(posedge clk);
    if (fail_count == 0 && bus_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
